[src/prt_pkg.sv]
// ----------------------------------------------------------------------------
// prt_pkg: shared types and codes of the point record table
// Transaction payloads, stored record layout, action and status codes.
// ----------------------------------------------------------------------------
package prt_pkg;

  // Default table depth
  localparam int CAPACITY_DEF = 32;

  // Action codes
  localparam logic [2:0] ACT_INSERT  = 3'd0;
  localparam logic [2:0] ACT_DEL_KEY = 3'd1;
  localparam logic [2:0] ACT_DEL_PT  = 3'd2;
  localparam logic [2:0] ACT_FIND_KEY = 3'd3;
  localparam logic [2:0] ACT_FIND_PT = 3'd4;
  localparam logic [2:0] ACT_RADIUS  = 3'd5;
  localparam logic [2:0] ACT_LIST    = 3'd6;

  // Status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;
  localparam logic [1:0] STS_EMPTY     = 2'd3;

  // Request transaction
  typedef struct packed {
    logic [2:0]         action;
    logic [63:0]        key;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] radius;
  } prt_req_t;

  // Response transaction
  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         slot;
    logic [63:0]        rec_key;
    logic signed [31:0] rec_x;
    logic signed [31:0] rec_y;
    logic [6:0]         fill;
    logic               last;
  } prt_rsp_t;

  // Stored record
  typedef struct packed {
    logic [63:0]        key;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } prt_rec_t;

endpackage

[src/prt_ram.sv]
// ----------------------------------------------------------------------------
// prt_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module prt_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/point_record_table.sv]
// ----------------------------------------------------------------------------
// point_record_table: packed table of keyed 2-D point records
// Insert, delete, find, radius query and list over records held in one RAM.
// ----------------------------------------------------------------------------
// Sequence: an insert answers through the decide and reply states; a scan passes each record
// examined through the scan and check states (adding the square and compare steps for a radius
// query, on the single RAM read port); a delete adds a shift-read and shift-write step per record
// shifted down. One request is processed at a time; the next request is taken while the
// final response waits in the output register.
// Reset clears the record count and control state; RAM contents are not cleared.
module point_record_table
  import prt_pkg::*;
#(
  parameter int CAPACITY = prt_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  prt_pkg::prt_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output prt_pkg::prt_rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DECIDE   = 9'b000000010,
    S_SCAN     = 9'b000000100,
    S_CHECK    = 9'b000001000,
    S_SQUARE   = 9'b000010000,
    S_COMPARE  = 9'b000100000,
    S_SHIFT_RD = 9'b001000000,
    S_SHIFT_WR = 9'b010000000,
    S_REPLY    = 9'b100000000
  } state_t;

  state_t      state;
  prt_req_t    req_q;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_inc;
  prt_rsp_t    res;
  logic        res_full;
  logic [31:0] dxa;
  logic [31:0] dya;
  logic [63:0] sqx;
  logic [63:0] sqy;
  logic [61:0] rr;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  prt_rec_t      ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  prt_rec_t      rd;

  logic        full;
  logic        key_hit;
  logic        pt_hit;
  logic        find_hit;
  logic        is_delete;
  logic        near;
  logic [32:0] dx;
  logic [32:0] dy;
  logic [32:0] dx_mag;
  logic [32:0] dy_mag;
  prt_rsp_t    hit_rsp;
  prt_rsp_t    miss_rsp;
  prt_rsp_t    ins_rsp;
  prt_rsp_t    empty_rsp;
  prt_rsp_t    rsp_next;
  logic        out_free;
  logic        push_ok;
  logic        collect;
  logic        out_load;
  logic        out_last;

  // Record storage
  prt_ram #(
    .WIDTH ($bits(prt_rec_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  assign req_stall = rst || (state != S_IDLE);
  assign idx_inc   = idx + CW'(1);
  assign full      = (count == CW'(CAPACITY));

  // Match and distance evaluation on the record just read
  always_comb begin
    key_hit   = (rd.key == req_q.key);
    pt_hit    = (rd.x == req_q.pos_x) && (rd.y == req_q.pos_y);
    find_hit  = (req_q.action == ACT_DEL_KEY || req_q.action == ACT_FIND_KEY) ?
                key_hit : pt_hit;
    is_delete = (req_q.action == ACT_DEL_KEY || req_q.action == ACT_DEL_PT);
    dx        = {rd.x[31], rd.x} - {req_q.pos_x[31], req_q.pos_x};
    dy        = {rd.y[31], rd.y} - {req_q.pos_y[31], req_q.pos_y};
    dx_mag    = dx[32] ? (33'd0 - dx) : dx;
    dy_mag    = dy[32] ? (33'd0 - dy) : dy;
    near      = ({1'b0, sqx} + {1'b0, sqy}) <= 65'(rr);

    hit_rsp         = '0;
    hit_rsp.status  = STS_OK;
    hit_rsp.slot    = 6'(idx[AW-1:0]);
    hit_rsp.rec_key = rd.key;
    hit_rsp.rec_x   = rd.x;
    hit_rsp.rec_y   = rd.y;

    miss_rsp        = '0;
    miss_rsp.status = STS_NOT_FOUND;

    // Insert answer: the new entry, or a bare full status
    ins_rsp = '0;
    if (full) begin
      ins_rsp.status = STS_FULL;
    end else begin
      ins_rsp.status  = STS_OK;
      ins_rsp.slot    = 6'(count[AW-1:0]);
      ins_rsp.rec_key = req_q.key;
      ins_rsp.rec_x   = req_q.pos_x;
      ins_rsp.rec_y   = req_q.pos_y;
    end

    empty_rsp        = '0;
    empty_rsp.status = STS_EMPTY;
  end

  // Output register control
  always_comb begin
    out_free = !rsp_valid || !rsp_stall;
    push_ok  = !res_full || out_free;
    collect  = ((state == S_CHECK) && (req_q.action == ACT_LIST)) ||
               ((state == S_COMPARE) && near);
    out_last = (state == S_REPLY);
    out_load = ((state == S_REPLY) && out_free) ||
               (collect && res_full && out_free);
    rsp_next      = res;
    rsp_next.fill = 7'(count);
    rsp_next.last = out_last;
  end

  // RAM port control
  always_comb begin
    ram_we    = ((state == S_DECIDE) && (req_q.action == ACT_INSERT) && !full) ||
                (state == S_SHIFT_WR);
    ram_waddr = (state == S_SHIFT_WR) ? idx[AW-1:0] : count[AW-1:0];
    ram_wdata = rd;
    if (state != S_SHIFT_WR) begin
      ram_wdata.key = req_q.key;
      ram_wdata.x   = req_q.pos_x;
      ram_wdata.y   = req_q.pos_y;
    end
    ram_re    = ((state == S_SCAN) && (idx != count)) ||
                ((state == S_SHIFT_RD) && (idx_inc < count));
    ram_raddr = (state == S_SHIFT_RD) ? idx_inc[AW-1:0] : idx[AW-1:0];
  end

  // Hold or send the response transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (out_load) begin
      rsp <= rsp_next;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      res_full <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q    <= req;
            idx      <= '0;
            res_full <= 1'b0;
            state    <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          unique case (req_q.action)
            ACT_INSERT: begin
              res <= ins_rsp;
              if (!full) begin
                count <= count + CW'(1);
              end
              state <= S_REPLY;
            end
            ACT_RADIUS: begin
              if (req_q.radius[31]) begin
                res   <= miss_rsp;
                state <= S_REPLY;
              end else begin
                rr    <= req_q.radius[30:0] * req_q.radius[30:0];
                state <= S_SCAN;
              end
            end
            ACT_LIST: begin
              if (count == '0) begin
                res   <= empty_rsp;
                state <= S_REPLY;
              end else begin
                state <= S_SCAN;
              end
            end
            ACT_DEL_KEY, ACT_DEL_PT, ACT_FIND_KEY, ACT_FIND_PT: begin
              state <= S_SCAN;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end

        // Issue the read of the next record, or finish the scan
        S_SCAN: begin
          if (idx == count) begin
            if (!res_full) begin
              res <= miss_rsp;
            end
            state <= S_REPLY;
          end else begin
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (req_q.action == ACT_RADIUS) begin
            dxa   <= dx_mag[31:0];
            dya   <= dy_mag[31:0];
            state <= S_SQUARE;
          end else if (req_q.action == ACT_LIST) begin
            if (push_ok) begin
              res      <= hit_rsp;
              res_full <= 1'b1;
              idx      <= idx_inc;
              state    <= S_SCAN;
            end
          end else if (find_hit) begin
            res   <= hit_rsp;
            state <= is_delete ? S_SHIFT_RD : S_REPLY;
          end else begin
            idx   <= idx_inc;
            state <= S_SCAN;
          end
        end

        S_SQUARE: begin
          sqx   <= dxa * dxa;
          sqy   <= dya * dya;
          state <= S_COMPARE;
        end

        S_COMPARE: begin
          if (!near) begin
            idx   <= idx_inc;
            state <= S_SCAN;
          end else if (push_ok) begin
            res      <= hit_rsp;
            res_full <= 1'b1;
            idx      <= idx_inc;
            state    <= S_SCAN;
          end
        end

        // Move later records down one slot
        S_SHIFT_RD: begin
          if (idx_inc < count) begin
            state <= S_SHIFT_WR;
          end else begin
            count <= count - CW'(1);
            state <= S_REPLY;
          end
        end

        S_SHIFT_WR: begin
          idx   <= idx_inc;
          state <= S_SHIFT_RD;
        end

        S_REPLY: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[verif/point_record_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_record_table_tb: self-checking bench for the point record table
// Drives insert, delete, find, radius and list requests, keeps a mirror of
// the packed record table, and checks every response transaction in order
// against the answers that mirror predicts. Both channels idle and stall at
// random, swapping roles between phases, with a final phase of full rate.
// ----------------------------------------------------------------------------
module point_record_table_tb;
  import prt_pkg::*;

  localparam int         TABLE_DEPTH = prt_pkg::CAPACITY_DEF;
  localparam logic [2:0] ACT_UNUSED  = 3'd7;
  localparam int         PHASE_ITEMS = 63;

  // Mirror of the record table and the queue of answers it predicts
  class table_tracker;
    prt_rec_t recs[TABLE_DEPTH];
    int       count;
    prt_rsp_t pending[$];
    int       mismatches;

    function new();
      count      = 0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void queue_rsp(logic [1:0] st, int slot, prt_rec_t e, bit last);
      prt_rsp_t p;
      p.status  = st;
      p.slot    = slot[5:0];
      p.rec_key = e.key;
      p.rec_x   = e.x;
      p.rec_y   = e.y;
      p.fill    = count[6:0];
      p.last    = last;
      pending.push_back(p);
    endfunction

    // Exact test of dx*dx + dy*dy <= r*r in wide arithmetic
    function bit in_circle(prt_rec_t e, prt_req_t r);
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [32:0]        mx;
      logic [32:0]        my;
      logic [65:0]        dist_sq;
      logic [65:0]        rad_sq;
      if (r.radius < 0) return 1'b0;
      dx      = $signed({e.x[31], e.x}) - $signed({r.pos_x[31], r.pos_x});
      dy      = $signed({e.y[31], e.y}) - $signed({r.pos_y[31], r.pos_y});
      mx      = (dx < 0) ? -dx : dx;
      my      = (dy < 0) ? -dy : dy;
      dist_sq = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
      rad_sq  = 66'(r.radius) * 66'(r.radius);
      return dist_sq <= rad_sq;
    endfunction

    // Apply one accepted request to the mirror and queue its answers
    function void note_request(prt_req_t r);
      int       hit;
      int       hits[$];
      prt_rec_t victim;
      prt_rec_t none;
      none = '0;
      hit  = -1;
      case (r.action)
        ACT_INSERT: begin
          if (count >= TABLE_DEPTH) begin
            queue_rsp(STS_FULL, 0, none, 1'b1);
          end else begin
            recs[count] = '{key: r.key, x: r.pos_x, y: r.pos_y};
            count++;
            queue_rsp(STS_OK, count - 1, recs[count - 1], 1'b1);
          end
        end
        ACT_DEL_KEY, ACT_DEL_PT, ACT_FIND_KEY, ACT_FIND_PT: begin
          for (int i = 0; i < count && hit < 0; i++) begin
            if ((r.action == ACT_DEL_KEY || r.action == ACT_FIND_KEY) ?
                (recs[i].key == r.key) :
                (recs[i].x == r.pos_x && recs[i].y == r.pos_y))
              hit = i;
          end
          if (hit < 0) begin
            queue_rsp(STS_NOT_FOUND, 0, none, 1'b1);
          end else begin
            victim = recs[hit];
            // Close the gap: later records shift down one slot
            if (r.action == ACT_DEL_KEY || r.action == ACT_DEL_PT) begin
              for (int i = hit; i < count - 1; i++) recs[i] = recs[i + 1];
              count--;
            end
            queue_rsp(STS_OK, hit, victim, 1'b1);
          end
        end
        ACT_RADIUS: begin
          for (int i = 0; i < count; i++) begin
            if (in_circle(recs[i], r)) hits.push_back(i);
          end
          if (hits.size() == 0) queue_rsp(STS_NOT_FOUND, 0, none, 1'b1);
        end
        ACT_LIST: begin
          if (count == 0) queue_rsp(STS_EMPTY, 0, none, 1'b1);
          for (int i = 0; i < count; i++) hits.push_back(i);
        end
        default: ;
      endcase
      // Multi-record answers in slot order, last marked on the final one
      for (int j = 0; j < hits.size(); j++)
        queue_rsp(STS_OK, hits[j], recs[hits[j]], j == hits.size() - 1);
    endfunction

    task check_response(prt_rsp_t got);
      prt_rsp_t want;
      if (pending.size() == 0) begin
        report($sformatf("response with none pending: status %0d slot %0d",
                         got.status, got.slot));
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.slot !== want.slot)
        report($sformatf("slot got %0d want %0d", got.slot, want.slot));
      if (got.rec_key !== want.rec_key)
        report($sformatf("rec_key got %h want %h", got.rec_key, want.rec_key));
      if (got.rec_x !== want.rec_x)
        report($sformatf("rec_x got %0d want %0d", got.rec_x, want.rec_x));
      if (got.rec_y !== want.rec_y)
        report($sformatf("rec_y got %0d want %0d", got.rec_y, want.rec_y));
      if (got.fill !== want.fill)
        report($sformatf("fill got %0d want %0d", got.fill, want.fill));
      if (got.last !== want.last)
        report($sformatf("last got %0d want %0d", got.last, want.last));
    endtask
  endclass

  logic     clk;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  prt_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  prt_rsp_t rsp;

  table_tracker tracker;
  int           send_idle_pct;
  int           recv_idle_pct;
  logic [63:0]  key_pool[8];

  point_record_table #(
    .CAPACITY (TABLE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("point_record_table_tb: errors");
    $finish;
  end

  // Check each accepted response and draw the next stall
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) tracker.check_response(rsp);
    rsp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Present one request, idling first at random, and hold it until taken
  task send_req(prt_req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    tracker.note_request(item);
  endtask

  function automatic prt_req_t make_req(logic [2:0] act, logic [63:0] key,
                                        logic signed [31:0] x,
                                        logic signed [31:0] y,
                                        logic signed [31:0] rad);
    prt_req_t r;
    r.action = act;
    r.key    = key;
    r.pos_x  = x;
    r.pos_y  = y;
    r.radius = rad;
    return r;
  endfunction

  // Mostly a small grid so points collide, sometimes full range or extremes
  function automatic logic signed [31:0] pick_coord();
    int p;
    p = $urandom_range(99);
    if (p < 60) return $urandom_range(8) - 4;
    if (p < 85) return $urandom;
    case ($urandom_range(3))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -1;
      default: return 0;
    endcase
  endfunction

  function automatic prt_req_t random_request(int insert_pct);
    prt_req_t r;
    int       idx;
    int       p;
    r.key    = ($urandom_range(99) < 75) ? key_pool[$urandom_range(7)]
                                         : {$urandom, $urandom};
    r.pos_x  = pick_coord();
    r.pos_y  = pick_coord();
    r.radius = $urandom;
    if ($urandom_range(99) < insert_pct) begin
      r.action = ACT_INSERT;
      return r;
    end
    case ($urandom_range(12))
      0, 1:    r.action = ACT_DEL_KEY;
      2, 3:    r.action = ACT_DEL_PT;
      4, 5:    r.action = ACT_FIND_KEY;
      6, 7:    r.action = ACT_FIND_PT;
      8, 9, 10: r.action = ACT_RADIUS;
      11:      r.action = ACT_LIST;
      default: r.action = ACT_UNUSED;
    endcase
    // Aim most lookups at a record that is really held
    if (tracker.count > 0 && $urandom_range(99) < 70) begin
      idx     = $urandom_range(tracker.count - 1);
      r.key   = tracker.recs[idx].key;
      r.pos_x = tracker.recs[idx].x;
      r.pos_y = tracker.recs[idx].y;
    end
    if (r.action == ACT_RADIUS) begin
      p = $urandom_range(99);
      if (p < 60)      r.radius = $urandom_range(8);
      else if (p < 80) r.radius = $urandom;
      else if (p < 90) r.radius = -($urandom_range(1, 8));
      else             r.radius = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  initial begin
    prt_req_t directed_reqs[$];
    tracker = new();
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    send_idle_pct = 27;
    recv_idle_pct = 58;

    // Empty table answers, extreme fields, duplicates, radius edges
    directed_reqs.push_back(make_req(ACT_LIST, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(ACT_FIND_KEY, 64'h1, 0, 0, 0));
    directed_reqs.push_back(make_req(ACT_DEL_PT, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(ACT_RADIUS, 0, 0, 0, 5));
    directed_reqs.push_back(make_req(ACT_INSERT, '1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
    directed_reqs.push_back(make_req(ACT_INSERT, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
    directed_reqs.push_back(make_req(ACT_INSERT, 64'hA5A5_5A5A_0F0F_F0F0, 0, 0, 0));
    directed_reqs.push_back(make_req(ACT_INSERT, 0, 3, -4, 0));
    directed_reqs.push_back(make_req(ACT_UNUSED, '1, -1, -1, -1));
    directed_reqs.push_back(make_req(ACT_FIND_KEY, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(ACT_FIND_PT, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(ACT_FIND_PT, 0, 1, 1, 0));
    directed_reqs.push_back(make_req(ACT_RADIUS, 0, 0, 0, 5));
    directed_reqs.push_back(make_req(ACT_RADIUS, 0, 0, 0, 4));
    directed_reqs.push_back(make_req(ACT_RADIUS, 0, 0, 0, -1));
    directed_reqs.push_back(make_req(ACT_RADIUS, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
    directed_reqs.push_back(make_req(ACT_RADIUS, 0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                     32'sh7FFF_FFFF));
    directed_reqs.push_back(make_req(ACT_LIST, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(ACT_DEL_KEY, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(ACT_DEL_PT, 0, 3, -4, 0));
    directed_reqs.push_back(make_req(ACT_DEL_KEY, 64'h1234, 0, 0, 0));
    directed_reqs.push_back(make_req(ACT_LIST, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_reqs[i]) send_req(directed_reqs[i]);

    // Fill toward full, then churn, then drain toward empty
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 27; recv_idle_pct = 58; end
        1: begin send_idle_pct = 58; recv_idle_pct = 27; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_req(random_request((phase == 0) ? 55 : (phase == 1) ? 35 : 20));
    end
    req_valid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (tracker.mismatches == 0)
      $display("point_record_table_tb: clean");
    else
      $display("point_record_table_tb: errors");
    $finish;
  end

endmodule
